// ===== src/assert_macros.svh =====
// Assertion macros used by the classifier top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/shzc_pkg.sv =====
// Shared types and constants of the segment hit zone classifier
`timescale 1ns / 1ps

package shzc_pkg;

  // Configuration port and field widths
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned RADIUS_W   = 16;
  localparam int unsigned DIST_W     = 25;
  localparam int unsigned HARM_W     = 2;
  localparam int unsigned AMP_W      = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_X        = 2'd0,
    REG_RIGHT_X       = 2'd1,
    REG_LINE_Y        = 2'd2,
    REG_HIT_RADIUS_SQ = 2'd3
  } cfg_reg_e;

  // Zone of a hit along the segment; ZONE_EDGE is an exact boundary
  typedef enum logic [1:0] {
    ZONE_EDGE = 2'd0,
    ZONE_NEAR = 2'd1,
    ZONE_MID  = 2'd2,
    ZONE_FAR  = 2'd3
  } zone_e;

  typedef struct packed {
    logic  hit;
    logic  excite;
    zone_e zone;
  } class_t;

  localparam logic [HARM_W-1:0]   HARM_RESET   = 2'd0;
  localparam logic [HARM_W-1:0]   HARM_NEAR    = 2'd3;
  localparam logic [HARM_W-1:0]   HARM_MID     = 2'd1;
  localparam logic [HARM_W-1:0]   HARM_FAR     = 2'd2;
  localparam logic [AMP_W-1:0]    AMP_LOW      = 7'd40;
  localparam logic [AMP_W-1:0]    AMP_HIGH     = 7'd70;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd225;

endpackage

// ===== src/shzc_classify.sv =====
// Hit test and zone compare on the squared distance terms
`timescale 1ns / 1ps

module shzc_classify #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [2*COORD_BITS-1:0]       dx_sq_i,
  input  logic [2*COORD_BITS-1:0]       dy_sq_i,
  input  logic [2*COORD_BITS-1:0]       dl_sq_i,
  input  logic [2*COORD_BITS-1:0]       len_sq_i,
  input  logic [shzc_pkg::RADIUS_W-1:0] radius_sq_i,
  output logic [2*COORD_BITS:0]         dist_o,
  output shzc_pkg::class_t              class_o
);

  localparam int unsigned SUM_W  = 2 * COORD_BITS + 1;
  localparam int unsigned WIDE_W = 2 * COORD_BITS + 5;

  logic [WIDE_W-1:0] d_left;
  logic [WIDE_W-1:0] nine_d;
  logic [WIDE_W-1:0] lsq;
  logic [WIDE_W-1:0] lsq4;
  logic              hit;
  shzc_pkg::zone_e   zone;

  // Distance to the segment and hit against the radius
  assign dist_o = SUM_W'(dx_sq_i) + SUM_W'(dy_sq_i);
  assign hit    = dist_o < SUM_W'(radius_sq_i);

  // Scale squared distance from the left end by nine, compare with one and four squared lengths
  assign d_left = WIDE_W'(dl_sq_i) + WIDE_W'(dy_sq_i);
  assign nine_d = (d_left << 3) + d_left;
  assign lsq    = WIDE_W'(len_sq_i);
  assign lsq4   = lsq << 2;

  always_comb begin
    if (nine_d < lsq) begin
      zone = shzc_pkg::ZONE_NEAR;
    end else if ((nine_d > lsq) && (nine_d < lsq4)) begin
      zone = shzc_pkg::ZONE_MID;
    end else if (nine_d > lsq4) begin
      zone = shzc_pkg::ZONE_FAR;
    end else begin
      zone = shzc_pkg::ZONE_EDGE;
    end
  end

  assign class_o.hit    = hit;
  assign class_o.excite = hit && (zone != shzc_pkg::ZONE_EDGE);
  assign class_o.zone   = zone;

endmodule

// ===== src/segment_hit_zone_classifier.sv =====
// Top level of the segment hit zone classifier
`timescale 1ns / 1ps

// Takes one point per clock and returns one result per point, in order.
// A point is held in the input register. The clamp, the four squared terms
// (one COORD_BITS by COORD_BITS multiplier each), the hit test, the zone
// compare and the stored harmonic and amplitude update all settle
// combinationally between the input and result registers. A result is valid
// once its point moves into the result register. One point per cycle flows
// while the result side keeps taking results. A held result stalls the input
// only once the input register is also full.
// Configuration is to be written only while no point is in flight; the block itself does not enforce it.

`include "assert_macros.svh"

module segment_hit_zone_classifier #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [shzc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shzc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Points in
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [COORD_BITS-1:0]           point_x_i,
  input  logic [COORD_BITS-1:0]           point_y_i,
  // Results out
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic                            excite_o,
  output logic [shzc_pkg::HARM_W-1:0]     harmonic_o,
  output logic [shzc_pkg::AMP_W-1:0]      amplitude_o,
  output logic [shzc_pkg::DIST_W-1:0]     distance_sq_o
);

  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = 2 * COORD_BITS + 1;

  // Configuration registers
  logic [COORD_BITS-1:0]         left_x_q;
  logic [COORD_BITS-1:0]         right_x_q;
  logic [COORD_BITS-1:0]         line_y_q;
  logic [shzc_pkg::RADIUS_W-1:0] radius_sq_q;

  // Pipeline registers, stage readiness and squared terms
  logic                  v1_q, out_valid_q;
  logic                  rdy1, rdy2;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [SQ_W-1:0]       dx_sq, dy_sq, dl_sq, len_sq;

  // Stored zone state and result fields
  logic [shzc_pkg::HARM_W-1:0] harmonic_q, harmonic_d;
  logic [shzc_pkg::AMP_W-1:0]  amplitude_q, amplitude_d;
  logic                        hit_q, excite_q;
  logic [shzc_pkg::DIST_W-1:0] dist_q;

  logic [COORD_BITS-1:0] lo, hi, cx;
  logic [COORD_BITS-1:0] dx, dy, dl, len;
  logic [SUM_W-1:0]      dist_sum;
  shzc_pkg::class_t      cls;

  // Accept configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_x_q    <= '0;
      right_x_q   <= '0;
      line_y_q    <= '0;
      radius_sq_q <= shzc_pkg::RADIUS_RESET;
    end else if (cfg_valid_i) begin
      unique case (shzc_pkg::cfg_reg_e'(cfg_index_i))
        shzc_pkg::REG_LEFT_X:        left_x_q    <= cfg_data_i[COORD_BITS-1:0];
        shzc_pkg::REG_RIGHT_X:       right_x_q   <= cfg_data_i[COORD_BITS-1:0];
        shzc_pkg::REG_LINE_Y:        line_y_q    <= cfg_data_i[COORD_BITS-1:0];
        shzc_pkg::REG_HIT_RADIUS_SQ: radius_sq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage readiness: a stage takes a new transaction when empty or draining
  assign rdy2       = !out_valid_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) out_valid_q <= v1_q;
    end
  end

  // Input register: hold the point
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  // Clamp to the segment span and take absolute differences
  assign lo  = (left_x_q <= right_x_q) ? left_x_q : right_x_q;
  assign hi  = (left_x_q <= right_x_q) ? right_x_q : left_x_q;
  assign cx  = (px_q < lo) ? lo : ((px_q > hi) ? hi : px_q);
  assign dx  = (px_q >= cx) ? (px_q - cx) : (cx - px_q);
  assign dy  = (py_q >= line_y_q) ? (py_q - line_y_q) : (line_y_q - py_q);
  assign dl  = (px_q >= left_x_q) ? (px_q - left_x_q) : (left_x_q - px_q);
  assign len = hi - lo;

  assign dx_sq  = SQ_W'(dx) * SQ_W'(dx);
  assign dy_sq  = SQ_W'(dy) * SQ_W'(dy);
  assign dl_sq  = SQ_W'(dl) * SQ_W'(dl);
  assign len_sq = SQ_W'(len) * SQ_W'(len);

  shzc_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .dx_sq_i     (dx_sq),
    .dy_sq_i     (dy_sq),
    .dl_sq_i     (dl_sq),
    .len_sq_i    (len_sq),
    .radius_sq_i (radius_sq_q),
    .dist_o      (dist_sum),
    .class_o     (cls)
  );

  // Pick the new harmonic and amplitude; keep them on a miss or a boundary
  always_comb begin
    harmonic_d  = harmonic_q;
    amplitude_d = amplitude_q;
    if (cls.excite) begin
      case (cls.zone)
        shzc_pkg::ZONE_NEAR: begin
          harmonic_d  = shzc_pkg::HARM_NEAR;
          amplitude_d = shzc_pkg::AMP_LOW;
        end
        shzc_pkg::ZONE_MID: begin
          harmonic_d  = shzc_pkg::HARM_MID;
          amplitude_d = shzc_pkg::AMP_HIGH;
        end
        shzc_pkg::ZONE_FAR: begin
          harmonic_d  = shzc_pkg::HARM_FAR;
          amplitude_d = shzc_pkg::AMP_LOW;
        end
        default: ;
      endcase
    end
  end

  // Advance stored state in item order as each transaction enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      harmonic_q  <= shzc_pkg::HARM_RESET;
      amplitude_q <= shzc_pkg::AMP_HIGH;
    end else if (rdy2 && v1_q) begin
      harmonic_q  <= harmonic_d;
      amplitude_q <= amplitude_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      hit_q    <= cls.hit;
      excite_q <= cls.excite;
      dist_q   <= shzc_pkg::DIST_W'(dist_sum);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign excite_o      = excite_q;
  assign harmonic_o    = harmonic_q;
  assign amplitude_o   = amplitude_q;
  assign distance_sq_o = dist_q;

  // Checks
  `ASSERT_IMPLIES(a_excite_needs_hit, out_valid_q && excite_q, hit_q,
                  "excite flagged without a hit")
  `ASSERT_ALWAYS(a_amp_legal,
                 (amplitude_q == shzc_pkg::AMP_LOW) || (amplitude_q == shzc_pkg::AMP_HIGH),
                 "stored amplitude out of range")
  `ASSERT_ALWAYS(a_amp_matches_harm,
                 ((harmonic_q == shzc_pkg::HARM_MID) || (harmonic_q == shzc_pkg::HARM_RESET))
                 == (amplitude_q == shzc_pkg::AMP_HIGH),
                 "stored amplitude disagrees with harmonic")
  `ASSERT_IMPLIES(a_excite_sets_harm, out_valid_q && excite_q,
                  harmonic_q != shzc_pkg::HARM_RESET,
                  "excite left harmonic at its reset value")

endmodule

// ===== dv/shzc_checker.sv =====
// Checker for the segment hit zone classifier: predicts each result and compares it
`timescale 1ns / 1ps

module shzc_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [shzc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shzc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [COORD_BITS-1:0]           point_x_i,
  input  logic [COORD_BITS-1:0]           point_y_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            hit_i,
  input  logic                            excite_i,
  input  logic [shzc_pkg::HARM_W-1:0]     harmonic_i,
  input  logic [shzc_pkg::AMP_W-1:0]      amplitude_i,
  input  logic [shzc_pkg::DIST_W-1:0]     distance_sq_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              hits_o,
  output int                              excites_o
);

  typedef struct packed {
    logic                        hit;
    logic                        excite;
    logic [shzc_pkg::HARM_W-1:0] harmonic;
    logic [shzc_pkg::AMP_W-1:0]  amplitude;
    logic [shzc_pkg::DIST_W-1:0] distance_sq;
  } zone_result_t;

  // Segment setup as seen on the register port
  logic [COORD_BITS-1:0]         seg_left;
  logic [COORD_BITS-1:0]         seg_right;
  logic [COORD_BITS-1:0]         seg_y;
  logic [shzc_pkg::RADIUS_W-1:0] radius_sq;

  // Stored pluck state
  logic [shzc_pkg::HARM_W-1:0]   harm_state;
  logic [shzc_pkg::AMP_W-1:0]    amp_state;

  zone_result_t          expected_q[$];
  int                    mismatch_count;
  int                    hit_count;
  int                    excite_count;

  // Classify one point against the segment and advance the stored harmonic and amplitude
  function automatic zone_result_t classify_point(input logic [COORD_BITS-1:0] px_in,
                                                   input logic [COORD_BITS-1:0] py_in);
    longint unsigned px, py, lft, rgt, lo, hi, cx, dx, dy, dist_sq, len, lsq, d, nine_d;
    shzc_pkg::zone_e zone;
    zone_result_t    r;
    px  = px_in;
    py  = py_in;
    lft = seg_left;
    rgt = seg_right;
    lo  = (lft <= rgt) ? lft : rgt;
    hi  = (lft <= rgt) ? rgt : lft;
    // Clamp to the segment span, then measure
    cx = px;
    if (cx < lo) cx = lo;
    if (cx > hi) cx = hi;
    dx      = (px >= cx) ? px - cx : cx - px;
    dy      = (py >= seg_y) ? py - seg_y : seg_y - py;
    dist_sq = dx * dx + dy * dy;
    r.hit    = (dist_sq < radius_sq);
    r.excite = 1'b0;
    if (r.hit) begin
      // Zone by squared distance from the left_x end against the squared length
      len    = (rgt >= lft) ? rgt - lft : lft - rgt;
      lsq    = len * len;
      dx     = (px >= lft) ? px - lft : lft - px;
      d      = dx * dx + dy * dy;
      nine_d = 9 * d;
      zone   = shzc_pkg::ZONE_EDGE;
      if (nine_d < lsq) zone = shzc_pkg::ZONE_NEAR;
      else if (nine_d > lsq && nine_d < 4 * lsq) zone = shzc_pkg::ZONE_MID;
      else if (nine_d > 4 * lsq) zone = shzc_pkg::ZONE_FAR;
      case (zone)
        shzc_pkg::ZONE_NEAR: begin
          harm_state = shzc_pkg::HARM_NEAR;
          amp_state  = shzc_pkg::AMP_LOW;
        end
        shzc_pkg::ZONE_MID: begin
          harm_state = shzc_pkg::HARM_MID;
          amp_state  = shzc_pkg::AMP_HIGH;
        end
        shzc_pkg::ZONE_FAR: begin
          harm_state = shzc_pkg::HARM_FAR;
          amp_state  = shzc_pkg::AMP_LOW;
        end
        default: ;
      endcase
      r.excite = (zone != shzc_pkg::ZONE_EDGE);
    end
    r.harmonic    = harm_state;
    r.amplitude   = amp_state;
    r.distance_sq = dist_sq[shzc_pkg::DIST_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [shzc_pkg::DIST_W-1:0] want,
                             input logic [shzc_pkg::DIST_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Track register writes, predict on each accepted point, compare each result
  always @(posedge clk_i or negedge rst_ni) begin : watch
    zone_result_t want;
    zone_result_t got;
    if (!rst_ni) begin
      seg_left       = '0;
      seg_right      = '0;
      seg_y          = '0;
      radius_sq      = shzc_pkg::RADIUS_RESET;
      harm_state     = shzc_pkg::HARM_RESET;
      amp_state      = shzc_pkg::AMP_HIGH;
      mismatch_count = 0;
      hit_count      = 0;
      excite_count   = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (shzc_pkg::cfg_reg_e'(cfg_index_i))
          shzc_pkg::REG_LEFT_X:        seg_left  = cfg_data_i[COORD_BITS-1:0];
          shzc_pkg::REG_RIGHT_X:       seg_right = cfg_data_i[COORD_BITS-1:0];
          shzc_pkg::REG_LINE_Y:        seg_y     = cfg_data_i[COORD_BITS-1:0];
          shzc_pkg::REG_HIT_RADIUS_SQ: radius_sq = cfg_data_i[shzc_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{hit_i, excite_i, harmonic_i, amplitude_i, distance_sq_i};
        if (expected_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing outstanding (hit %0b, distance_sq %0d)",
                   $time, hit_i, distance_sq_i);
        end else begin
          want = expected_q.pop_front();
          check_field("hit", want.hit, got.hit);
          check_field("excite", want.excite, got.excite);
          check_field("harmonic", want.harmonic, got.harmonic);
          check_field("amplitude", want.amplitude, got.amplitude);
          check_field("distance_sq", want.distance_sq, got.distance_sq);
          if (want.hit) hit_count++;
          if (want.excite) excite_count++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(classify_point(point_x_i, point_y_i));
      end
    end
    errors_o  <= mismatch_count;
    pending_o <= expected_q.size();
    hits_o    <= hit_count;
    excites_o <= excite_count;
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top: drives points and register writes into the classifier and gives the verdict
`timescale 1ns / 1ps

module tb;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int          NUM_PHASES  = 10;
  localparam int          PHASE_ITEMS = 85;
  localparam int          CYCLE_LIMIT = 200000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [shzc_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [shzc_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [COORD_BITS-1:0]           point_x_i;
  logic [COORD_BITS-1:0]           point_y_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            hit_o;
  logic                            excite_o;
  logic [shzc_pkg::HARM_W-1:0]     harmonic_o;
  logic [shzc_pkg::AMP_W-1:0]      amplitude_o;
  logic [shzc_pkg::DIST_W-1:0]     distance_sq_o;

  int errors;
  int pending;
  int hits;
  int excites;

  int idle_pct;
  int stall_pct;
  int points_sent;
  int reg_writes;
  int setups;
  int cycles;

  // Segment as last written, used to aim random points
  int seg_lo;
  int seg_hi;
  int seg_y;

  segment_hit_zone_classifier #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .excite_o     (excite_o),
    .harmonic_o   (harmonic_o),
    .amplitude_o  (amplitude_o),
    .distance_sq_o(distance_sq_o)
  );

  shzc_checker #(
    .COORD_BITS(COORD_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_i        (hit_o),
    .excite_i     (excite_o),
    .harmonic_i   (harmonic_o),
    .amplitude_i  (amplitude_o),
    .distance_sq_i(distance_sq_o),
    .errors_o     (errors),
    .pending_o    (pending),
    .hits_o       (hits),
    .excites_o    (excites)
  );

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one point, idling first at random, and hold it until the transaction
  task automatic send_point(input int px, input int py);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    point_x_i  = px[COORD_BITS-1:0];
    point_y_i  = py[COORD_BITS-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    points_sent++;
  endtask

  // Drop the point channel and hold until every result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input shzc_pkg::cfg_reg_e idx,
                           input logic [shzc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    reg_writes++;
  endtask

  // Write a whole segment setup; upper data bits of coordinates carry junk
  task automatic set_segment(input int lft, input int rgt, input int y, input int radius);
    write_reg(shzc_pkg::REG_LEFT_X, {4'($urandom_range(0, 15)), 12'(lft)});
    write_reg(shzc_pkg::REG_RIGHT_X, {4'($urandom_range(0, 15)), 12'(rgt)});
    write_reg(shzc_pkg::REG_LINE_Y, {4'($urandom_range(0, 15)), 12'(y)});
    write_reg(shzc_pkg::REG_HIT_RADIUS_SQ, 16'(radius));
    seg_lo = (lft <= rgt) ? lft : rgt;
    seg_hi = (lft <= rgt) ? rgt : lft;
    seg_y  = y;
    setups++;
  endtask

  // Pick a segment shape and radius at random
  task automatic random_setup();
    int a;
    int b;
    int tmp;
    int radius;
    a = $urandom_range(0, COORD_MAX);
    case ($urandom_range(0, 7))
      0: b = a;
      1: begin
        a = 0;
        b = COORD_MAX;
      end
      2: b = $urandom_range(0, COORD_MAX);
      default: begin
        b = a + $urandom_range(1, 600);
        if (b > COORD_MAX) b = COORD_MAX;
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    case ($urandom_range(0, 5))
      0: radius = 0;
      1: radius = 65535;
      2: radius = $urandom_range(1, 400);
      default: radius = $urandom_range(0, 65535);
    endcase
    set_segment(a, b, $urandom_range(0, COORD_MAX), radius);
  endtask

  // Mostly aim near the segment so hits and zone changes happen; some anywhere
  task automatic send_random_point();
    int x;
    int y;
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, COORD_MAX);
      y = $urandom_range(0, COORD_MAX);
    end else begin
      x = $urandom_range(seg_lo, seg_hi + 600) - 300;
      y = seg_y + $urandom_range(0, 540) - 270;
      if (x < 0) x = 0;
      if (x > COORD_MAX) x = COORD_MAX;
      if (y < 0) y = 0;
      if (y > COORD_MAX) y = COORD_MAX;
    end
    send_point(x, y);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = shzc_pkg::REG_LEFT_X;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    out_ready_i = 1'b0;
    idle_pct    = 34;
    stall_pct   = 60;
    points_sent = 0;
    reg_writes  = 0;
    setups      = 0;
    cycles      = 0;
    seg_lo      = 0;
    seg_hi      = 0;
    seg_y       = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setup: zero-length segment at the origin
    send_point(0, 0);
    send_point(COORD_MAX, COORD_MAX);
    drain();

    // Forward segment: each zone, both boundaries, clamped ends, radius edge
    set_segment(100, 1000, 500, 225);
    send_point(110, 500);
    send_point(400, 500);
    send_point(500, 500);
    send_point(700, 500);
    send_point(900, 500);
    send_point(90, 500);
    send_point(1010, 505);
    send_point(500, 515);
    send_point(500, 514);
    send_point(0, 0);
    drain();

    // Reversed ends: zones still measured from left_x
    set_segment(1000, 100, 500, 225);
    send_point(950, 500);
    send_point(110, 500);
    send_point(700, 500);
    drain();

    // Zero length away from the origin
    set_segment(2000, 2000, 2000, 100);
    send_point(2005, 2000);
    send_point(2000, 2000);
    send_point(2000, 2010);
    drain();

    // Full-span segment on the top row with the widest radius, then none
    set_segment(0, COORD_MAX, COORD_MAX, 65535);
    send_point(COORD_MAX, COORD_MAX);
    send_point(0, COORD_MAX);
    send_point(2048, 3840);
    drain();
    write_reg(shzc_pkg::REG_HIT_RADIUS_SQ, 16'd0);
    send_point(100, COORD_MAX);
    drain();

    // Largest distance the fields allow
    set_segment(0, 0, 0, 65535);
    send_point(COORD_MAX, COORD_MAX);
    drain();

    // Random part: receiver-heavy stalling, then sender-heavy idling, then none
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 4) begin
        idle_pct  = 34;
        stall_pct = 60;
      end else if (phase < 7) begin
        idle_pct  = 60;
        stall_pct = 34;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      random_setup();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off mid-phase until every result is back
        if (n == PHASE_ITEMS / 2) drain();
        send_random_point();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("tb: %0d points over %0d segment setups, %0d register writes",
             points_sent, setups, reg_writes);
    $display("tb: %0d hits, %0d of them excited a zone", hits, excites);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
